// ===== rtl/core/wpsc_pkg.sv =====
// Package for the wide length-prefixed string checker.
// Holds the byte constants, the frame state enum and the result struct.
// Has no dependencies; every other file of the block uses it.
`default_nettype none

package wpsc_pkg;

  // Byte constants for the checks.
  localparam logic [7:0] PrintLo    = 8'h20;
  localparam logic [7:0] PrintHi    = 8'h7e;
  localparam logic [7:0] MaxShortLen = 8'd2;
  localparam logic [7:0] SpaceLen    = 8'd3;
  localparam logic [7:0] SpaceChar   = 8'h20;

  // Field widths of one result item.
  localparam int unsigned CharW = 7;
  localparam int unsigned LenW  = 9;

  // Frame state: waiting for a length byte or taking body bytes.
  typedef enum logic {
    ST_WAIT_LEN = 1'b0,
    ST_BODY     = 1'b1
  } wpsc_state_e;

  // One result item.
  typedef struct packed {
    logic [CharW-1:0] text_char;
    logic             char_valid;
    logic [CharW-1:0] char_index;
    logic             frame_done;
    logic             string_ok;
    logic [LenW-1:0]  encoded_length;
  } wpsc_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/wpsc_frame_fsm.sv =====
// Frame state machine and per-byte checks of the string checker.
// Holds the frame state, declared length, position and verdict registers.
// Depends on wpsc_pkg.
`default_nettype none

module wpsc_frame_fsm (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire logic [7:0]            byte_i,
  output wpsc_pkg::wpsc_result_t     res_o
);

  wpsc_pkg::wpsc_state_e state_q, state_d;
  logic [7:0] len_q, len_d;
  logic [7:0] pos_q, pos_d;
  logic       ok_q, ok_d;

  logic [7:0] pos_next;
  logic       is_last;
  logic       byte_bad;
  logic       verdict_ok;

  // State registers update only when an item passes through.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wpsc_pkg::ST_WAIT_LEN;
      len_q   <= '0;
      pos_q   <= '0;
      ok_q    <= 1'b1;
    end else if (step_i) begin
      state_q <= state_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      ok_q    <= ok_d;
    end
  end

  assign pos_next = pos_q + 8'd1;
  assign is_last  = (pos_next == len_q);

  // A body byte is bad when it breaks the rule for its position.
  always_comb begin
    if (is_last) begin
      byte_bad = (byte_i != 8'd0);
    end else if (pos_next[0]) begin
      byte_bad = (byte_i < wpsc_pkg::PrintLo) || (byte_i > wpsc_pkg::PrintHi) ||
                 ((len_q == wpsc_pkg::SpaceLen) && (byte_i == wpsc_pkg::SpaceChar));
    end else begin
      byte_bad = (byte_i != 8'd0);
    end
  end

  assign verdict_ok = ok_q && !byte_bad;

  // Next state and the result item for the current byte.
  always_comb begin
    state_d = state_q;
    len_d   = len_q;
    pos_d   = pos_q;
    ok_d    = ok_q;
    res_o   = '0;
    case (state_q)
      wpsc_pkg::ST_WAIT_LEN: begin
        if (byte_i <= wpsc_pkg::MaxShortLen) begin
          res_o.frame_done = 1'b1;
        end else begin
          state_d = wpsc_pkg::ST_BODY;
          len_d   = byte_i;
          pos_d   = '0;
          ok_d    = 1'b1;
        end
      end
      wpsc_pkg::ST_BODY: begin
        pos_d = pos_next;
        ok_d  = verdict_ok;
        if (is_last) begin
          res_o.frame_done = 1'b1;
          if (verdict_ok) begin
            res_o.string_ok      = 1'b1;
            res_o.encoded_length = {1'b0, len_q} + 9'd1;
          end
          state_d = wpsc_pkg::ST_WAIT_LEN;
          len_d   = '0;
          pos_d   = '0;
          ok_d    = 1'b1;
        end else if (pos_next[0]) begin
          // Characters go out even when they fail the check.
          res_o.text_char  = byte_i[6:0];
          res_o.char_valid = 1'b1;
          res_o.char_index = pos_q[7:1];
        end
      end
      default: begin
        state_d = wpsc_pkg::ST_WAIT_LEN;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/wpsc_out_reg.sv =====
// Result register of the string checker with valid/stall handshake.
// Loads a new item whenever it is empty or its item is being taken.
// Depends on wpsc_pkg.
`default_nettype none

module wpsc_out_reg (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  load_i,
  input  wire wpsc_pkg::wpsc_result_t res_i,
  input  wire logic                  out_stall_i,
  output logic                       out_valid_o,
  output logic                       ready_o,
  output wpsc_pkg::wpsc_result_t     res_o
);

  logic                   valid_q;
  wpsc_pkg::wpsc_result_t res_q;

  // The register can take a new item unless a held item is stalled.
  assign ready_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  // Payload carries no reset.
  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== rtl/core/wide_pascal_string_checker_core.sv =====
// Wide length-prefixed string checker, top level.
// Throughput: one byte per cycle while out_stall_i does not hold the
// result register; an input register feeds one pass of
// compare and counter logic into a result register.
// Reset: rst_ni clears the valid bits of both stages and returns the frame
// state to waiting for a length byte.
`default_nettype none

module wide_pascal_string_checker_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [7:0]                  data_byte_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  output logic [wpsc_pkg::CharW-1:0]       text_char_o,
  output logic                             char_valid_o,
  output logic [wpsc_pkg::CharW-1:0]       char_index_o,
  output logic                             frame_done_o,
  output logic                             string_ok_o,
  output logic [wpsc_pkg::LenW-1:0]        encoded_length_o,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i
);

  logic                   in_valid_q;
  logic [7:0]             in_byte_q;
  logic                   adv;
  logic                   step;
  wpsc_pkg::wpsc_result_t res_d;
  wpsc_pkg::wpsc_result_t res_q;

  // The input register moves on when the result register can load.
  assign step       = in_valid_q && adv;
  assign in_stall_o = in_valid_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_byte_q <= data_byte_i;
    end
  end

  // Per-byte checks and frame state.
  wpsc_frame_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .res_o  (res_d)
  );

  // Result register.
  wpsc_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_valid_q),
    .res_i       (res_d),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .ready_o     (adv),
    .res_o       (res_q)
  );

  assign text_char_o      = res_q.text_char;
  assign char_valid_o     = res_q.char_valid;
  assign char_index_o     = res_q.char_index;
  assign frame_done_o     = res_q.frame_done;
  assign string_ok_o      = res_q.string_ok;
  assign encoded_length_o = res_q.encoded_length;

endmodule

`default_nettype wire
